/* rtl/ptqfg_pkg.sv */
// ----------------------------------------------------------------------------
// ptqfg_pkg
// shared types and constants of the paced transmit queue with feedback gate
// ----------------------------------------------------------------------------
package ptqfg_pkg;

  // item codes
  typedef enum logic [1:0] {
    ACT_ARRIVE   = 2'd0,
    ACT_FEEDBACK = 2'd1,
    ACT_TICK     = 2'd2,
    ACT_NONE     = 2'd3
  } action_t;

  // configuration register indexes
  localparam int CFG_IDX_W = 1;
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BUFFER_LIMIT  = 1'b0,
    CFG_INITIAL_DELAY = 1'b1
  } cfg_idx_t;

  localparam logic [8:0]  BUFFER_LIMIT_RST = 9'd200;
  localparam logic [15:0] INIT_DELAY_RST   = 16'd0;

  // net sends that must be exceeded before the extra delay grows by one tenth
  localparam int SEND_BATCH = 30;

  // reciprocal of ten: floor(x / 10) == (x * RECIP10) >> RECIP10_SH for 32-bit x
  localparam logic [31:0] RECIP10    = 32'hCCCC_CCCD;
  localparam int          RECIP10_SH = 35;

  localparam logic [23:0]        DELAY_MAX = 24'hFF_FFFF;
  localparam logic [15:0]        LOSS_MAX  = 16'hFFFF;
  localparam logic signed [15:0] BAL_MAX   = 16'sh7FFF;
  localparam logic signed [15:0] BAL_MIN   = -16'sh8000;

  typedef struct packed {
    logic [15:0] duration;
    logic [15:0] tag;
  } entry_t;

  typedef struct packed {
    action_t     action;
    logic [15:0] pkt_duration;
    logic [15:0] pkt_tag;
    logic        next_allowed;
  } item_t;

  typedef struct packed {
    logic        sent_valid;
    logic [15:0] sent_tag;
    logic [15:0] sent_duration;
    logic        dropped;
    logic [8:0]  queue_length;
    logic [15:0] loss_level;
  } result_t;

endpackage

/* rtl/ptqfg_store.sv */
// ----------------------------------------------------------------------------
// ptqfg_store
// packet memory, one write and one registered read port with write forwarding
// ----------------------------------------------------------------------------
module ptqfg_store #(
  parameter int DEPTH = 256,
  parameter int AW    = 8
) (
  input  logic                clk,
  input  logic                wr_en,
  input  logic [AW-1:0]       wr_addr,
  input  ptqfg_pkg::entry_t   wr_data,
  input  logic [AW-1:0]       rd_addr,
  output ptqfg_pkg::entry_t   rd_data
);

  ptqfg_pkg::entry_t mem [DEPTH];
  ptqfg_pkg::entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // a write to the entry being fetched is passed straight through
  always_ff @(posedge clk) begin
    if (wr_en && (wr_addr == rd_addr)) begin
      rd_data_r <= wr_data;
    end else begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

/* rtl/ptqfg_ctrl.sv */
// ----------------------------------------------------------------------------
// ptqfg_ctrl
// queue pointers, service timer, feedback gate, loss and delay counters
// ----------------------------------------------------------------------------
module ptqfg_ctrl #(
  parameter int DEPTH = 256,
  parameter int AW    = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                go,
  input  ptqfg_pkg::item_t    item,
  input  logic [8:0]          buffer_limit,
  input  logic                delay_load,
  input  logic [15:0]         delay_init,
  output logic                mem_wr_en,
  output logic [AW-1:0]       mem_wr_addr,
  output ptqfg_pkg::entry_t   mem_wr_data,
  output logic [AW-1:0]       mem_rd_addr,
  input  ptqfg_pkg::entry_t   mem_rd_data,
  output ptqfg_pkg::result_t  result
);

  localparam int OW = $clog2(DEPTH + 1);
  localparam int LW = (OW > 9) ? OW : 9;

  logic [AW-1:0]        head_r, head_nxt;
  logic [OW-1:0]        occ_r, occ_nxt;
  ptqfg_pkg::entry_t    hd_r, hd_nxt;
  logic                 run_r, run_nxt;
  logic [16:0]          rem_r, rem_nxt;
  logic                 gate_r, gate_nxt;
  logic signed [15:0]   bal_r, bal_nxt;
  logic [15:0]          loss_r, loss_nxt;
  logic [23:0]          delay_r, delay_nxt;

  logic [LW-1:0]        limit;
  logic                 arrive, tick, fback, drop, push, expire_now, send, grow;
  logic [OW-1:0]        occ_a;
  logic [16:0]          rem_dec;
  logic [AW:0]          tail_sum, hinc_sum, rinc_sum;
  logic [AW-1:0]        head_inc;
  ptqfg_pkg::entry_t    new_ent, out_ent;
  logic signed [15:0]   bal_inc;
  logic [55:0]          div_prod;
  logic [24:0]          grown_sum;
  logic [23:0]          grown, delay_use;

  // floor(x * 11 / 10) == x + floor(x / 10)
  assign div_prod  = 56'(delay_r) * 56'(ptqfg_pkg::RECIP10);
  assign grown_sum = {1'b0, delay_r} + 25'(div_prod >> ptqfg_pkg::RECIP10_SH);
  assign grown     = grown_sum[24] ? ptqfg_pkg::DELAY_MAX : grown_sum[23:0];

  assign limit = (LW'(buffer_limit) > LW'(DEPTH)) ? LW'(DEPTH) : LW'(buffer_limit);

  assign hinc_sum = {1'b0, head_r} + (AW+1)'(1);
  assign head_inc = (hinc_sum >= (AW+1)'(DEPTH)) ? AW'(hinc_sum - (AW+1)'(DEPTH))
                                                   : hinc_sum[AW-1:0];
  assign tail_sum = {1'b0, head_r} + (AW+1)'(occ_r);
  assign new_ent  = '{duration: item.pkt_duration, tag: item.pkt_tag};

  always_comb begin
    arrive = 1'b0;
    tick   = 1'b0;
    fback  = 1'b0;
    if (go) begin
      unique case (item.action)
        ptqfg_pkg::ACT_ARRIVE:   arrive = 1'b1;
        ptqfg_pkg::ACT_FEEDBACK: fback  = 1'b1;
        ptqfg_pkg::ACT_TICK:     tick   = 1'b1;
        default:                 ;
      endcase
    end
  end

  always_comb begin
    drop       = arrive && (LW'(occ_r) >= limit);
    push       = arrive && !drop;
    occ_a      = occ_r + OW'(push);
    rem_dec    = (rem_r != 17'd0) ? rem_r - 17'd1 : rem_r;
    expire_now = (push && !run_r) || (tick && run_r && (rem_dec == 17'd0));
    send       = expire_now && (occ_a != '0) && gate_r;
    // an empty queue sends the arriving packet itself
    out_ent    = (occ_r == '0) ? new_ent : hd_r;

    bal_inc   = (bal_r < ptqfg_pkg::BAL_MAX) ? bal_r + 16'sd1 : bal_r;
    grow      = send && (bal_inc > 16'(ptqfg_pkg::SEND_BATCH));
    delay_use = grow ? grown : delay_r;

    head_nxt  = send ? head_inc : head_r;
    occ_nxt   = occ_a - OW'(send);

    priority if (send && (occ_r >= OW'(2))) begin
      hd_nxt = mem_rd_data;
    end else if (send || (occ_r == '0)) begin
      hd_nxt = new_ent;
    end else begin
      hd_nxt = hd_r;
    end

    run_nxt = run_r;
    rem_nxt = rem_r;
    if (send) begin
      run_nxt = 1'b1;
      rem_nxt = 17'(out_ent.duration) + 17'(delay_use[23:8]);
    end else if (expire_now) begin
      run_nxt = 1'b0;
      rem_nxt = '0;
    end else if (tick && run_r) begin
      rem_nxt = rem_dec;
    end

    gate_nxt = fback ? item.next_allowed : gate_r;
    bal_nxt  = bal_r;
    if (grow) begin
      bal_nxt = '0;
    end else if (send) begin
      bal_nxt = bal_inc;
    end else if (fback && (bal_r > ptqfg_pkg::BAL_MIN)) begin
      bal_nxt = bal_r - 16'sd1;
    end

    delay_nxt = delay_load ? {delay_init, 8'd0} : (grow ? grown : delay_r);

    loss_nxt = loss_r;
    if (drop && (loss_r != ptqfg_pkg::LOSS_MAX)) begin
      loss_nxt = loss_r + 16'd1;
    end else if (push && (loss_r != 16'd0)) begin
      loss_nxt = loss_r - 16'd1;
    end
  end

  // memory side: append at the tail, keep the entry behind the head fetched
  assign mem_wr_en   = push;
  assign mem_wr_addr = (tail_sum >= (AW+1)'(DEPTH)) ? AW'(tail_sum - (AW+1)'(DEPTH))
                                                      : tail_sum[AW-1:0];
  assign mem_wr_data = new_ent;
  assign rinc_sum    = {1'b0, head_nxt} + (AW+1)'(1);
  assign mem_rd_addr = (rinc_sum >= (AW+1)'(DEPTH)) ? AW'(rinc_sum - (AW+1)'(DEPTH))
                                                      : rinc_sum[AW-1:0];

  always_comb begin
    logic [LW-1:0] occ_ext;
    occ_ext                = LW'(occ_nxt);
    result.sent_valid      = send;
    result.sent_tag        = send ? out_ent.tag : 16'd0;
    result.sent_duration   = send ? out_ent.duration : 16'd0;
    result.dropped         = drop;
    result.queue_length    = occ_ext[8:0];
    result.loss_level      = loss_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      occ_r   <= '0;
      run_r   <= 1'b0;
      rem_r   <= '0;
      gate_r  <= 1'b1;
      bal_r   <= '0;
      loss_r  <= '0;
      delay_r <= {ptqfg_pkg::INIT_DELAY_RST, 8'd0};
    end else begin
      head_r  <= head_nxt;
      occ_r   <= occ_nxt;
      run_r   <= run_nxt;
      rem_r   <= rem_nxt;
      gate_r  <= gate_nxt;
      bal_r   <= bal_nxt;
      loss_r  <= loss_nxt;
      delay_r <= delay_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hd_r <= hd_nxt;
  end

  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= OW'(DEPTH))
    else $error("queue occupancy above depth");

  a_stopped_clear: assert property (@(posedge clk) disable iff (!rst_n)
    !run_r |-> (rem_r == 17'd0))
    else $error("stopped timer holds a count");

  a_drop_no_send: assert property (@(posedge clk) disable iff (!rst_n)
    drop |-> (!send && $stable(occ_r) == $stable(occ_r) && occ_nxt == occ_r))
    else $error("dropped arrival changed the queue or sent");

  a_send_runs: assert property (@(posedge clk) disable iff (!rst_n)
    send |=> run_r)
    else $error("timer not running after a departure");

  a_idle_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !go |=> ($stable(occ_r) && $stable(head_r) && $stable(loss_r)))
    else $error("queue state moved without an item");

endmodule

/* rtl/paced_tx_queue_with_feedback_gate_unit.sv */
// ----------------------------------------------------------------------------
// paced_tx_queue_with_feedback_gate_unit
// transmit queue with drop-on-full, receiver feedback gate and paced service
// ----------------------------------------------------------------------------
// pipeline: an item is taken into the input register, and its result is
//   held in the result register until it is taken; the queue update itself
//   lands at the same edge that loads the result register
// throughput: one item per cycle while out_stall stays low; the packet
//   memory has one write and one registered read port per cycle
// reset (rst_n low, synchronous): queue empty, timer stopped, gate open,
//   counters zero, buffer_limit 200, initial_delay 0; packet memory is
//   left as is and needs no clearing pass
module paced_tx_queue_with_feedback_gate_unit #(
  parameter int QUEUE_DEPTH = 256
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // item input
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [1:0]                          in_action,
  input  logic [15:0]                         in_pkt_duration,
  input  logic [15:0]                         in_pkt_tag,
  input  logic                                in_next_allowed,
  // result output
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                out_sent_valid,
  output logic [15:0]                         out_sent_tag,
  output logic [15:0]                         out_sent_duration,
  output logic                                out_dropped,
  output logic [8:0]                          out_queue_length,
  output logic [15:0]                         out_loss_level,
  // configuration writes
  input  logic                                cfg_wr_en,
  input  logic [ptqfg_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [15:0]                         cfg_wdata
);

  localparam int AW = $clog2(QUEUE_DEPTH);

  // input register stage
  logic               s1_valid_r, s1_valid_nxt;
  ptqfg_pkg::item_t   s1_item_r;
  // result register stage
  logic               out_valid_r, out_valid_nxt;
  ptqfg_pkg::result_t out_res_r;
  ptqfg_pkg::result_t res;

  logic               go;
  logic               in_take;
  logic [8:0]         buffer_limit_r, buffer_limit_nxt;
  logic               delay_load;

  logic               mem_wr_en;
  logic [AW-1:0]      mem_wr_addr, mem_rd_addr;
  ptqfg_pkg::entry_t  mem_wr_data, mem_rd_data;

  // the held item is processed when the result register is free or drains
  assign go       = s1_valid_r && !(out_valid_r && out_stall);
  assign in_stall = s1_valid_r && !go;
  assign in_take  = in_valid && !in_stall;

  assign s1_valid_nxt  = in_take || (s1_valid_r && !go);
  assign out_valid_nxt = go || (out_valid_r && out_stall);

  // config decode; the delay write also reloads the working delay
  always_comb begin
    buffer_limit_nxt = buffer_limit_r;
    delay_load       = 1'b0;
    if (cfg_wr_en) begin
      unique case (ptqfg_pkg::cfg_idx_t'(cfg_index))
        ptqfg_pkg::CFG_BUFFER_LIMIT:  buffer_limit_nxt = cfg_wdata[8:0];
        ptqfg_pkg::CFG_INITIAL_DELAY: delay_load       = 1'b1;
        default:                      ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r     <= 1'b0;
      out_valid_r    <= 1'b0;
      buffer_limit_r <= ptqfg_pkg::BUFFER_LIMIT_RST;
    end else begin
      s1_valid_r     <= s1_valid_nxt;
      out_valid_r    <= out_valid_nxt;
      buffer_limit_r <= buffer_limit_nxt;
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_item_r <= '{action:       ptqfg_pkg::action_t'(in_action),
                     pkt_duration: in_pkt_duration,
                     pkt_tag:      in_pkt_tag,
                     next_allowed: in_next_allowed};
    end
    if (go) begin
      out_res_r <= res;
    end
  end

  ptqfg_store #(
    .DEPTH (QUEUE_DEPTH),
    .AW    (AW)
  ) u_store (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  ptqfg_ctrl #(
    .DEPTH (QUEUE_DEPTH),
    .AW    (AW)
  ) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .go           (go),
    .item         (s1_item_r),
    .buffer_limit (buffer_limit_r),
    .delay_load   (delay_load),
    .delay_init   (cfg_wdata),
    .mem_wr_en    (mem_wr_en),
    .mem_wr_addr  (mem_wr_addr),
    .mem_wr_data  (mem_wr_data),
    .mem_rd_addr  (mem_rd_addr),
    .mem_rd_data  (mem_rd_data),
    .result       (res)
  );

  assign out_valid         = out_valid_r;
  assign out_sent_valid    = out_res_r.sent_valid;
  assign out_sent_tag      = out_res_r.sent_tag;
  assign out_sent_duration = out_res_r.sent_duration;
  assign out_dropped       = out_res_r.dropped;
  assign out_queue_length  = out_res_r.queue_length;
  assign out_loss_level    = out_res_r.loss_level;

  a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && out_valid_r))
    else $error("input stalled with nothing held");

  a_go_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
    go |=> out_valid_r)
    else $error("processed item left no result");

  a_one_outcome: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_res_r.sent_valid == 1'b0 && out_res_r.sent_tag != 16'd0))
    else $error("result carries a tag without a departure");

endmodule
